// ===== design/kmp_pkg.sv =====
// Shared types and codes for the KMP substring search block.
`timescale 1ns / 1ps

package kmp_pkg;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 16;

    localparam logic [1:0] OP_NEW    = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_HAY    = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_FOUND     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOADJ,
        ST_CMP
    } t_state;

endpackage

// ===== design/kmp_substring_search.sv =====
// Streaming KMP substring search: needle load, failure table build, matcher.
// Needle byte: a new needle, a first byte or a dropped byte is taken in the idle state; an append
//   goes through ST_LOADJ, then ST_CMP with its failure-chain fallbacks, each one read of the two RAMs.
// Haystack byte: ST_CMP with its fallbacks (taken in the idle state when the search already reported).
// A result is registered at the end of its last step, which repeats while the output is full.
// Sync active-low reset clears control state; needle and failure RAMs are not cleared.
`timescale 1ns / 1ps

module kmp_substring_search #(
    parameter int MAX_PATTERN = 32,
    parameter int INDEX_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [kmp_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // [7:0] data_byte
    input  logic [kmp_pkg::S_TUSER_W-1:0] i_s_axis_tuser,  // [1:0] op
    input  logic                          i_s_axis_tlast,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [kmp_pkg::M_TDATA_W-1:0] o_m_axis_tdata   // [1:0] status, [17:2] position
);

    import kmp_pkg::*;

    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int ADDR_W = MAX_PATTERN > 1 ? $clog2(MAX_PATTERN) : 1;
    localparam int SUM_W  = (INDEX_BITS > LEN_W ? INDEX_BITS : LEN_W) + 1;
    localparam int WIDE_W = INDEX_BITS > POS_W ? INDEX_BITS : POS_W;

    t_state                r_state, n_state;
    logic                  r_app, n_app;
    logic [7:0]            r_byte, n_byte;
    logic                  r_last, n_last;
    logic [LEN_W-1:0]      r_j, n_j;
    logic [LEN_W-1:0]      r_len, n_len;
    logic [LEN_W-1:0]      r_match, n_match;
    logic [INDEX_BITS-1:0] r_text, n_text;
    logic                  r_done, n_done;
    logic                  r_ovf, n_ovf;
    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic [POS_W-1:0]      r_out_pos, n_out_pos;

    logic                  store_we, fail_we;
    logic [ADDR_W-1:0]     store_waddr, fail_waddr, store_raddr, fail_raddr;
    logic [7:0]            store_wdata, store_q;
    logic [LEN_W-1:0]      fail_wdata, fail_q;

    logic                  s_fire, can_emit, mismatch, finish, emit_req;
    logic [LEN_W-1:0]      j_next, j_m1, len_m1, match_m1, fq_m1;
    logic [INDEX_BITS-1:0] pos_full;
    logic [WIDE_W-1:0]     pos_wide;
    logic [POS_W-1:0]      pos_cap;
    logic [STATUS_W-1:0]   emit_status;
    logic [POS_W-1:0]      emit_pos;

    kmp_sdp_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN)) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (store_wdata),
        .i_raddr (store_raddr),
        .o_rdata (store_q)
    );

    kmp_sdp_ram #(.WIDTH(LEN_W), .DEPTH(MAX_PATTERN)) u_fail (
        .i_clk   (i_clk),
        .i_we    (fail_we),
        .i_waddr (fail_waddr),
        .i_wdata (fail_wdata),
        .i_raddr (fail_raddr),
        .o_rdata (fail_q)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign can_emit        = !r_out_valid || i_m_axis_tready;

    assign j_m1     = r_j - 1'b1;
    assign len_m1   = r_len - 1'b1;
    assign match_m1 = r_match - 1'b1;
    assign fq_m1    = fail_q - 1'b1;

    assign mismatch = (r_j != '0) && (r_byte != store_q);
    assign j_next   = (r_byte == store_q) ? r_j + 1'b1 : r_j;

    // match start: saturated index reports the saturation value
    assign pos_full = (r_text == {INDEX_BITS{1'b1}}) ? r_text :
                      INDEX_BITS'(SUM_W'(r_text) + SUM_W'(1) - SUM_W'(r_len));
    assign pos_wide = WIDE_W'(pos_full);
    assign pos_cap  = (pos_wide > WIDE_W'({POS_W{1'b1}})) ? {POS_W{1'b1}} : pos_wide[POS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_app       <= 1'b0;
            r_len       <= '0;
            r_match     <= '0;
            r_text      <= '0;
            r_done      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_app       <= n_app;
            r_len       <= n_len;
            r_match     <= n_match;
            r_text      <= n_text;
            r_done      <= n_done;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte       <= n_byte;
        r_last       <= n_last;
        r_j          <= n_j;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
    end

    always_comb begin
        n_state      = r_state;
        n_app        = r_app;
        n_byte       = r_byte;
        n_last       = r_last;
        n_j          = r_j;
        n_len        = r_len;
        n_match      = r_match;
        n_text       = r_text;
        n_done       = r_done;
        n_ovf        = r_ovf;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_valid  = (r_out_valid && !i_m_axis_tready);

        store_we    = 1'b0;
        store_waddr = r_len[ADDR_W-1:0];
        store_wdata = i_s_axis_tdata;
        fail_we     = 1'b0;
        fail_waddr  = r_len[ADDR_W-1:0];
        fail_wdata  = '0;
        store_raddr = r_j[ADDR_W-1:0];
        fail_raddr  = j_m1[ADDR_W-1:0];

        finish      = 1'b0;
        emit_req    = 1'b0;
        emit_status = STAT_FOUND;
        emit_pos    = '0;

        case (r_state)
            ST_IDLE: begin
                store_raddr = r_match[ADDR_W-1:0];
                fail_raddr  = (i_s_axis_tuser == OP_APPEND) ? len_m1[ADDR_W-1:0] :
                                                              match_m1[ADDR_W-1:0];
                if (s_fire) begin
                    n_byte = i_s_axis_tdata;
                    n_last = i_s_axis_tlast;
                    case (i_s_axis_tuser)
                        OP_NEW: begin
                            n_match     = '0;
                            n_text      = '0;
                            n_done      = 1'b0;
                            n_ovf       = 1'b0;
                            n_len       = LEN_W'(1);
                            store_we    = 1'b1;
                            store_waddr = '0;
                            fail_we     = 1'b1;
                            fail_waddr  = '0;
                        end
                        OP_APPEND: begin
                            n_match = '0;
                            n_text  = '0;
                            n_done  = 1'b0;
                            if (r_len == LEN_W'(MAX_PATTERN)) begin
                                n_ovf = 1'b1;
                            end else if (r_len == '0) begin
                                n_len      = LEN_W'(1);
                                store_we   = 1'b1;
                                fail_we    = 1'b1;
                            end else begin
                                store_we = 1'b1;
                                n_app    = 1'b1;
                                n_state  = ST_LOADJ;
                            end
                        end
                        OP_HAY: begin
                            if (r_done) begin
                                if (i_s_axis_tlast) begin
                                    n_match = '0;
                                    n_text  = '0;
                                    n_done  = 1'b0;
                                end
                            end else begin
                                n_app   = 1'b0;
                                n_j     = r_match;
                                n_state = ST_CMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_LOADJ: begin
                n_j         = fail_q;
                store_raddr = fail_q[ADDR_W-1:0];
                fail_raddr  = fq_m1[ADDR_W-1:0];
                n_state     = ST_CMP;
            end

            ST_CMP: begin
                if (r_app) begin
                    if (mismatch) begin
                        n_j         = fail_q;
                        store_raddr = fail_q[ADDR_W-1:0];
                        fail_raddr  = fq_m1[ADDR_W-1:0];
                    end else begin
                        fail_we    = 1'b1;
                        fail_wdata = j_next;
                        n_len      = r_len + 1'b1;
                        n_state    = ST_IDLE;
                    end
                end else if (r_ovf) begin
                    finish      = 1'b1;
                    emit_req    = r_last;
                    emit_status = STAT_OVERFLOW;
                end else if (r_len == '0) begin
                    finish   = 1'b1;
                    emit_req = 1'b1;
                end else if (mismatch) begin
                    n_j         = fail_q;
                    store_raddr = fail_q[ADDR_W-1:0];
                    fail_raddr  = fq_m1[ADDR_W-1:0];
                end else begin
                    finish = 1'b1;
                    if (j_next >= r_len) begin
                        emit_req = 1'b1;
                        emit_pos = pos_cap;
                    end else if (r_last) begin
                        emit_req    = 1'b1;
                        emit_status = STAT_NOT_FOUND;
                    end
                end

                // result waits here while the output register is still full
                if (finish && (!emit_req || can_emit)) begin
                    n_state = ST_IDLE;
                    if (emit_req) begin
                        n_out_valid  = 1'b1;
                        n_out_status = emit_status;
                        n_out_pos    = emit_pos;
                        if (emit_status == STAT_FOUND) begin
                            n_done = 1'b1;
                        end
                    end
                    if (!r_ovf && (r_len != '0)) begin
                        n_match = (j_next >= r_len) ? '0 : j_next;
                    end
                    if (r_text != {INDEX_BITS{1'b1}}) begin
                        n_text = r_text + 1'b1;
                    end
                    if (r_last) begin
                        n_match = '0;
                        n_text  = '0;
                        n_done  = 1'b0;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(M_TDATA_W - POS_W - STATUS_W)'(0), r_out_pos, r_out_status};

endmodule

// ===== design/kmp_sdp_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps

module kmp_sdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/kmp_chk.sv =====
// Port-level checks for the KMP substring search block, bound to the top level.
`timescale 1ns / 1ps

module kmp_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic [kmp_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [kmp_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);

    import kmp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result transaction dropped or changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[1:0] == STAT_FOUND) ||
                            (o_m_axis_tdata[1:0] == STAT_NOT_FOUND) ||
                            (o_m_axis_tdata[1:0] == STAT_OVERFLOW))
        else $error("unused status code");

    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[1:0] != STAT_FOUND) |-> o_m_axis_tdata[17:2] == '0)
        else $error("nonzero position without a match");

    a_needle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser != OP_HAY)
        |=> !$rose(o_m_axis_tvalid))
        else $error("needle transaction produced a result");

endmodule

bind kmp_substring_search kmp_chk u_kmp_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the streaming KMP substring search block.
`timescale 1ns / 1ps

module tb_top;

    import kmp_pkg::*;

    localparam int NEEDLE_MAX = 32;
    localparam int IDLE_LIMIT = 2000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
    } t_search_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata = '0;  // [7:0] data_byte
    logic [S_TUSER_W-1:0] i_s_axis_tuser = '0;  // [1:0] op
    logic                 i_s_axis_tlast = 1'b0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;       // [1:0] status, [17:2] position

    kmp_substring_search uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // predicted search state
    logic [7:0]      needle_mem [NEEDLE_MAX];
    logic [5:0]      border_mem [NEEDLE_MAX];
    logic [5:0]      needle_len = '0;
    logic [5:0]      match_len = '0;
    logic [15:0]     hay_index = '0;
    logic            search_over = 1'b0;
    logic            needle_too_long = 1'b0;

    t_search_result  results_due [$];
    int              mismatch_count = 0;
    int              items_sent = 0;
    int              idle_cycles = 0;
    int              sender_idle_pct = 0;
    int              sink_stall_pct = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic void restart_search();
        match_len   = '0;
        hay_index   = '0;
        search_over = 1'b0;
    endfunction

    function automatic void grow_needle(input logic [7:0] b);
        logic [5:0] j;
        if (needle_len >= NEEDLE_MAX) begin
            needle_too_long = 1'b1;
        end else begin
            needle_mem[needle_len] = b;
            j = '0;
            if (needle_len != 0) begin
                j = border_mem[needle_len - 1];
                while (j > 0 && j < NEEDLE_MAX && b != needle_mem[j])
                    j = border_mem[j - 1];
                if (j < NEEDLE_MAX && b == needle_mem[j])
                    j++;
            end
            border_mem[needle_len] = j;
            needle_len++;
        end
    endfunction

    function automatic void kmp_step(input logic [1:0] op, input logic [7:0] b,
                                     input logic lst);
        logic [5:0]     j;
        t_search_result res;
        case (op)
            OP_NEW: begin
                needle_len      = '0;
                needle_too_long = 1'b0;
                restart_search();
                grow_needle(b);
            end
            OP_APPEND: begin
                restart_search();
                grow_needle(b);
            end
            OP_HAY: begin
                if (!search_over) begin
                    if (needle_too_long) begin
                        if (lst) begin
                            res.status   = STAT_OVERFLOW;
                            res.position = '0;
                            results_due.push_back(res);
                        end
                    end else if (needle_len == 0) begin
                        res.status   = STAT_FOUND;
                        res.position = '0;
                        results_due.push_back(res);
                        search_over = 1'b1;
                    end else begin
                        j = match_len;
                        while (j > 0 && j < NEEDLE_MAX && b != needle_mem[j])
                            j = border_mem[j - 1];
                        if (j < NEEDLE_MAX && b == needle_mem[j])
                            j++;
                        if (j >= needle_len) begin
                            res.status = STAT_FOUND;
                            if (hay_index == 16'hFFFF)
                                res.position = 16'hFFFF;
                            else
                                res.position = hay_index + 16'd1 - 16'(needle_len);
                            results_due.push_back(res);
                            search_over = 1'b1;
                            j = '0;
                        end else if (lst) begin
                            res.status   = STAT_NOT_FOUND;
                            res.position = '0;
                            results_due.push_back(res);
                        end
                        match_len = j;
                    end
                    if (hay_index != 16'hFFFF)
                        hay_index++;
                end
                if (lst)
                    restart_search();
            end
            default: ;
        endcase
    endfunction

    initial begin : result_checker
        logic                 fire;
        logic [M_TDATA_W-1:0] word;
        t_search_result       want;
        forever begin
            @(negedge i_clk);
            fire = o_m_axis_tvalid && i_m_axis_tready && i_rst_n;
            word = o_m_axis_tdata;
            @(posedge i_clk);
            if (fire) begin
                if (results_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual 0x%06h",
                             $time, word);
                end else begin
                    want = results_due.pop_front();
                    if (word[1:0] !== want.status) begin
                        mismatch_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, word[1:0]);
                    end
                    if (word[17:2] !== want.position) begin
                        mismatch_count++;
                        $display("%0t: position expected %0d actual %0d",
                                 $time, want.position, word[17:2]);
                    end
                    if (word[M_TDATA_W-1:18] !== '0) begin
                        mismatch_count++;
                        $display("%0t: pad bits expected 0 actual 0x%0h",
                                 $time, word[M_TDATA_W-1:18]);
                    end
                end
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic lst);
        logic ready;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= op;
        i_s_axis_tlast  <= lst;
        do begin
            @(negedge i_clk);
            ready = o_s_axis_tready;
            @(posedge i_clk);
        end while (!ready);
        kmp_step(op, b, lst);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic wait_results_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_due.size() != 0);
    endtask

    function automatic logic [7:0] next_symbol(input logic [7:0] s0, input logic [7:0] s1);
        if ($urandom_range(15) == 0)
            return 8'($urandom);
        return $urandom_range(1) ? s1 : s0;
    endfunction

    task automatic test_directed();
        // empty needle after reset, then silent bytes until last
        send_item(OP_HAY, 8'h00, 1'b0);
        send_item(OP_HAY, 8'hFF, 1'b0);
        send_item(OP_HAY, 8'h55, 1'b1);
        send_item(OP_UNUSED, 8'hAA, 1'b1);
        send_item(OP_NEW, 8'hFF, 1'b1);
        send_item(OP_HAY, 8'h00, 1'b0);
        send_item(OP_HAY, 8'hFF, 1'b1);
        // "aab" exercises a failure fallback
        send_item(OP_NEW, 8'h61, 1'b0);
        send_item(OP_APPEND, 8'h61, 1'b0);
        send_item(OP_APPEND, 8'h62, 1'b0);
        send_item(OP_HAY, 8'h61, 1'b0);
        send_item(OP_HAY, 8'h61, 1'b0);
        send_item(OP_HAY, 8'h61, 1'b0);
        send_item(OP_HAY, 8'h62, 1'b1);
        // haystack shorter than needle
        send_item(OP_HAY, 8'h61, 1'b1);
        send_item(OP_HAY, 8'h61, 1'b0);
        send_item(OP_HAY, 8'h61, 1'b0);
        send_item(OP_HAY, 8'h62, 1'b0);
        send_item(OP_HAY, 8'h62, 1'b1);
        // append in the middle of a search restarts it
        send_item(OP_HAY, 8'h61, 1'b0);
        send_item(OP_APPEND, 8'h63, 1'b0);
        send_item(OP_HAY, 8'h61, 1'b0);
        send_item(OP_HAY, 8'h61, 1'b0);
        send_item(OP_HAY, 8'h62, 1'b0);
        send_item(OP_HAY, 8'h63, 1'b1);
    endtask

    task automatic test_overflow();
        logic [7:0] full_needle [NEEDLE_MAX];
        for (int k = 0; k < NEEDLE_MAX; k++)
            full_needle[k] = 8'($urandom);
        for (int k = 0; k < NEEDLE_MAX; k++)
            send_item((k == 0) ? OP_NEW : OP_APPEND, full_needle[k], 1'b0);
        for (int k = 0; k < NEEDLE_MAX; k++)
            send_item(OP_HAY, full_needle[k], k == NEEDLE_MAX - 1);
        send_item(OP_APPEND, 8'hFF, 1'b0);
        send_item(OP_HAY, full_needle[0], 1'b0);
        send_item(OP_HAY, full_needle[1], 1'b1);
        send_item(OP_HAY, 8'h00, 1'b1);
        send_item(OP_APPEND, 8'h00, 1'b0);
        send_item(OP_HAY, 8'h80, 1'b1);
        send_item(OP_NEW, 8'h11, 1'b0);
        send_item(OP_HAY, 8'h11, 1'b1);
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct, input int n_items);
        int         target;
        int         plen;
        logic [7:0] s0;
        logic [7:0] s1;
        logic [7:0] needle [$];
        logic [7:0] hay [$];
        wait_results_drained();
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 4))
                    send_item(2'($urandom_range(3)), 8'($urandom), 1'($urandom));
            end else begin
                s0 = 8'($urandom);
                s1 = 8'($urandom);
                plen = ($urandom_range(11) == 0) ? $urandom_range(7, 34)
                                                 : $urandom_range(1, 6);
                needle.delete();
                for (int k = 0; k < plen; k++)
                    needle.push_back(next_symbol(s0, s1));
                for (int k = 0; k < plen; k++)
                    send_item((k == 0) ? OP_NEW : OP_APPEND, needle[k], 1'($urandom));
                repeat ($urandom_range(1, 3)) begin
                    hay.delete();
                    repeat ($urandom_range(0, 10))
                        hay.push_back(next_symbol(s0, s1));
                    if ($urandom_range(1))
                        foreach (needle[k])
                            hay.push_back(needle[k]);
                    repeat ($urandom_range(0, 10))
                        hay.push_back(next_symbol(s0, s1));
                    if (hay.size() == 0)
                        hay.push_back(next_symbol(s0, s1));
                    foreach (hay[k])
                        send_item(OP_HAY, hay[k], k == hay.size() - 1);
                end
            end
        end
    endtask

    task automatic test_random();
        random_phase(0, 0, 150);
        random_phase(46, 0, 150);
        random_phase(0, 46, 150);
        random_phase(26, 26, 150);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_overflow();
        test_random();
        wait_results_drained();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/kmp_pkg.sv
design/kmp_sdp_ram.sv
design/kmp_substring_search.sv
design/kmp_chk.sv
tb/tb_top.sv
